// ===== hdl/cfr_pkg.sv =====
// Package for the clock frame replacement unit: action, status and state codes,
// fixed payload widths and the result record. No dependencies.
package cfr_pkg;

  localparam int ACTION_W = 3;
  localparam int SLOT_W   = 6;
  localparam int OWNER_W  = 8;
  localparam int PAGE_W   = 20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE  = 3'd1,
    ACT_PIN   = 3'd2,
    ACT_UNPIN = 3'd3,
    ACT_TOUCH = 3'd4,
    ACT_DROP  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EVICT    = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_DROP,
    S_SLOT,
    S_FINISH
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   granted;
    logic [PAGE_W-1:0]   vpage;
    logic [OWNER_W-1:0]  vowner;
    logic                vdirty;
  } result_t;

endpackage

// ===== hdl/cfr_ifs.sv =====
// Request and response channel interfaces of the clock frame replacement unit.
// Depends on cfr_pkg for the payload widths.
interface cfr_req_if import cfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   frame_slot;
  logic [OWNER_W-1:0]  owner;
  logic [PAGE_W-1:0]   user_page;
  logic                is_write;

  modport source (output valid, action, frame_slot, owner, user_page, is_write,
                  input ready);
  modport sink   (input valid, action, frame_slot, owner, user_page, is_write,
                  output ready);
endinterface

interface cfr_rsp_if import cfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [SLOT_W-1:0]  granted_slot;
  logic [PAGE_W-1:0]  victim_page;
  logic [OWNER_W-1:0] victim_owner;
  logic               victim_dirty;

  modport source (output valid, status, granted_slot, victim_page, victim_owner,
                  victim_dirty, input ready);
  modport sink   (input valid, status, granted_slot, victim_page, victim_owner,
                  victim_dirty, output ready);
endinterface

// ===== hdl/cfr_frame_mem.sv =====
// Frame table storage: one write port and one read port with registered read data.
// No package dependencies.
module cfr_frame_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/clock_frame_replacement_unit.sv =====
// Channel  Direction  Handshake     Payload
// req      in         valid/ready   action, frame_slot, owner, user_page, is_write
// rsp      out        valid/ready   status, granted_slot, victim_page, victim_owner, victim_dirty
//
// One item at a time. Free, pin, unpin and touch read one entry and write it back if it
// is valid; drop owner scans every entry; allocate runs a free-slot scan and, if no slot
// is free, a clock walk of up to two turns. The frame memory has one read port and one
// write port, one entry read and at most one written per cycle. After reset a clearing
// pass writes every entry with req.ready low. A result waits in the output register;
// a new request is accepted meanwhile, and only completion stalls on rsp.
module clock_frame_replacement_unit import cfr_pkg::*; #(
  parameter int FRAME_COUNT = 64,
  parameter int OWNER_BITS  = 8,
  parameter int PAGE_BITS   = 20
) (
  input  logic      clk,
  input  logic      rst,
  cfr_req_if.sink   req,
  cfr_rsp_if.source rsp
);

  localparam int AW = $clog2(FRAME_COUNT);
  localparam int EW = 4 + OWNER_BITS + PAGE_BITS;
  localparam int B_VALID  = EW - 1;
  localparam int B_PINNED = EW - 2;
  localparam int B_ACC    = EW - 3;
  localparam int B_DIRTY  = EW - 4;
  localparam logic [AW-1:0] LAST_IDX  = AW'(FRAME_COUNT - 1);
  localparam logic [AW:0]   WALK_LAST = (AW + 1)'(2 * FRAME_COUNT - 1);

  state_t state, state_next;
  logic [AW-1:0] exam_idx, exam_idx_next;
  logic [AW:0]   walk_cnt, walk_cnt_next;
  logic [AW-1:0] hand, hand_next;
  result_t       res, res_next;
  result_t       out_res;
  logic          out_valid;

  action_t               act;
  logic [OWNER_BITS-1:0] own;
  logic [PAGE_BITS-1:0]  page;
  logic                  wr;

  logic          mem_we;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] rdata;
  logic [EW-1:0] new_entry;
  logic [AW-1:0] idx_inc;
  logic          finish_go;

  cfr_frame_mem #(.DEPTH(FRAME_COUNT), .WIDTH(EW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (exam_idx),
    .wdata (mem_wdata),
    .raddr (exam_idx_next),
    .rdata (rdata)
  );

  assign new_entry = {4'b1000, own, page};
  assign idx_inc   = (exam_idx == LAST_IDX) ? '0 : exam_idx + 1'b1;
  assign finish_go = (state == S_FINISH) && (!out_valid || rsp.ready);
  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      exam_idx <= '0;
      walk_cnt <= '0;
      hand     <= '0;
    end else begin
      state    <= state_next;
      exam_idx <= exam_idx_next;
      walk_cnt <= walk_cnt_next;
      hand     <= hand_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (req.valid && req.ready) begin
      act  <= action_t'(req.action);
      own  <= OWNER_BITS'(req.owner);
      page <= PAGE_BITS'(req.user_page);
      wr   <= req.is_write;
    end
  end

  // The scan, walk and drop states issue the read for the next entry in the same cycle
  // as they examine one, so the memory delivers one entry per cycle.
  always_comb begin
    state_next    = state;
    exam_idx_next = exam_idx;
    walk_cnt_next = walk_cnt;
    hand_next     = hand;
    res_next      = res;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        exam_idx_next = idx_inc;
        if (exam_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          res_next = '0;
          unique case (action_t'(req.action))
            ACT_ALLOC: begin
              exam_idx_next = '0;
              state_next = S_SCAN;
            end
            ACT_FREE, ACT_PIN, ACT_UNPIN, ACT_TOUCH: begin
              if (int'(req.frame_slot) < FRAME_COUNT) begin
                exam_idx_next = AW'(req.frame_slot);
                state_next = S_SLOT;
              end else begin
                res_next.status = ST_BAD_SLOT;
                state_next = S_FINISH;
              end
            end
            ACT_DROP: begin
              exam_idx_next = '0;
              state_next = S_DROP;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (!rdata[B_VALID]) begin
          mem_we = 1'b1;
          mem_wdata = new_entry;
          res_next.granted = SLOT_W'(exam_idx);
          state_next = S_FINISH;
        end else if (exam_idx == LAST_IDX) begin
          exam_idx_next = hand;
          walk_cnt_next = '0;
          state_next = S_WALK;
        end else begin
          exam_idx_next = idx_inc;
        end
      end
      S_WALK: begin
        if (!rdata[B_PINNED] && !rdata[B_ACC]) begin
          mem_we = 1'b1;
          mem_wdata = new_entry;
          res_next.status  = ST_EVICT;
          res_next.granted = SLOT_W'(exam_idx);
          res_next.vpage   = PAGE_W'(rdata[PAGE_BITS-1:0]);
          res_next.vowner  = OWNER_W'(rdata[PAGE_BITS +: OWNER_BITS]);
          res_next.vdirty  = rdata[B_DIRTY];
          hand_next = idx_inc;
          state_next = S_FINISH;
        end else begin
          if (!rdata[B_PINNED]) begin
            mem_we = 1'b1;
            mem_wdata = rdata;
            mem_wdata[B_ACC] = 1'b0;
          end
          if (walk_cnt == WALK_LAST) begin
            // Two full turns examined every entry without finding a victim.
            res_next.status = ST_NO_FRAME;
            state_next = S_FINISH;
          end else begin
            exam_idx_next = idx_inc;
            walk_cnt_next = walk_cnt + 1'b1;
          end
        end
      end
      S_DROP: begin
        if (rdata[B_VALID] && (rdata[PAGE_BITS +: OWNER_BITS] == own)) begin
          mem_we = 1'b1;
        end
        if (exam_idx == LAST_IDX) begin
          state_next = S_FINISH;
        end else begin
          exam_idx_next = idx_inc;
        end
      end
      S_SLOT: begin
        if (!rdata[B_VALID]) begin
          res_next.status = ST_BAD_SLOT;
        end else begin
          mem_we = 1'b1;
          mem_wdata = rdata;
          unique case (act)
            ACT_FREE:  mem_wdata = '0;
            ACT_PIN:   mem_wdata[B_PINNED] = 1'b1;
            ACT_UNPIN: mem_wdata[B_PINNED] = 1'b0;
            ACT_TOUCH: begin
              mem_wdata[B_ACC] = 1'b1;
              mem_wdata[B_DIRTY] = rdata[B_DIRTY] | wr;
            end
            default: mem_wdata = rdata;
          endcase
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (finish_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_res <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_res.status;
  assign rsp.granted_slot = out_res.granted;
  assign rsp.victim_page  = out_res.vpage;
  assign rsp.victim_owner = out_res.vowner;
  assign rsp.victim_dirty = out_res.vdirty;

  // The hand moves only during a clock walk.
  a_hand_still: assert property (@(posedge clk) disable iff (rst)
    (state != S_WALK) |=> $stable(hand))
    else $error("hand moved outside a clock walk");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_cnt <= WALK_LAST))
    else $error("clock walk ran past two turns");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_EVICT)) |->
      (rsp.victim_page == '0 && rsp.victim_owner == '0 && !rsp.victim_dirty))
    else $error("victim fields set without an eviction");

  a_granted_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_NO_FRAME || rsp.status == ST_BAD_SLOT)) |->
      (rsp.granted_slot == '0))
    else $error("slot granted on a failed request");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the clock frame replacement unit.
// Depends on cfr_pkg, cfr_req_if/cfr_rsp_if and clock_frame_replacement_unit.
module tb_top import cfr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = 64;

  typedef struct {
    logic          valid;
    logic          pinned;
    logic          accessed;
    logic          dirty;
    logic [7:0]    owner;
    logic [19:0]   page;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cfr_req_if req();
  cfr_rsp_if rsp();

  clock_frame_replacement_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  frame_t     frame_tbl[FRAMES];
  logic [5:0] shadow_hand;
  result_t    expected_results[$];
  int         error_count = 0;
  int         result_count = 0;
  int         evict_count = 0;
  int         noframe_count = 0;
  bit         send_gaps = 1'b1;
  bit         recv_gaps = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Applies one request to the shadow frame table and returns the expected result.
  function automatic result_t frame_table_apply(input logic [2:0] act, input logic [5:0] slot,
                                                input logic [7:0] own, input logic [19:0] pg,
                                                input logic wr);
    result_t r;
    int      pick;
    int      h;
    bit      found;
    r = '0;
    r.status = ST_OK;
    pick = 0;
    found = 1'b0;
    case (act)
      ACT_ALLOC: begin
        for (int s = 0; s < FRAMES; s++) begin
          if (!found && !frame_tbl[s].valid) begin
            pick = s;
            found = 1'b1;
          end
        end
        if (!found) begin
          h = int'(shadow_hand);
          for (int n = 0; n < 2 * FRAMES && !found; n++) begin
            if (!frame_tbl[h].pinned) begin
              if (frame_tbl[h].accessed) begin
                frame_tbl[h].accessed = 1'b0;
              end else begin
                pick = h;
                found = 1'b1;
              end
            end
            h = (h + 1) % FRAMES;
          end
          shadow_hand = h[5:0];
          if (found) begin
            r.status = ST_EVICT;
            r.vpage  = frame_tbl[pick].page;
            r.vowner = frame_tbl[pick].owner;
            r.vdirty = frame_tbl[pick].dirty;
          end else begin
            r.status = ST_NO_FRAME;
          end
        end
        if (found) begin
          frame_tbl[pick] = '{1'b1, 1'b0, 1'b0, 1'b0, own, pg};
          r.granted = pick[5:0];
        end
      end
      ACT_FREE, ACT_PIN, ACT_UNPIN, ACT_TOUCH: begin
        if (!frame_tbl[slot].valid) begin
          r.status = ST_BAD_SLOT;
        end else if (act == ACT_FREE) begin
          frame_tbl[slot] = '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 20'd0};
        end else if (act == ACT_PIN) begin
          frame_tbl[slot].pinned = 1'b1;
        end else if (act == ACT_UNPIN) begin
          frame_tbl[slot].pinned = 1'b0;
        end else begin
          frame_tbl[slot].accessed = 1'b1;
          if (wr) frame_tbl[slot].dirty = 1'b1;
        end
      end
      ACT_DROP: begin
        for (int s = 0; s < FRAMES; s++) begin
          if (frame_tbl[s].valid && frame_tbl[s].owner == own)
            frame_tbl[s] = '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 20'd0};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Valid stays high between back-to-back transfers; it drops only for an idle
  // burst or while waiting for the results to drain.
  task automatic send_request(input logic [2:0] act, input logic [5:0] slot,
                              input logic [7:0] own, input logic [19:0] pg,
                              input logic wr);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.action     <= act;
    req.frame_slot <= slot;
    req.owner      <= own;
    req.user_page  <= pg;
    req.is_write   <= wr;
    do @(posedge clk); while (!req.ready);
    expected_results.push_back(frame_table_apply(act, slot, own, pg, wr));
    @(negedge clk);
  endtask

  // Receiver: random stall bursts, compares every transfer with the oldest expectation.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 16) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(rsp.status), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (want.status == ST_EVICT) evict_count++;
        if (want.status == ST_NO_FRAME) noframe_count++;
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.granted_slot !== want.granted)
          report_mismatch("granted_slot", 32'(rsp.granted_slot), 32'(want.granted));
        if (rsp.victim_page !== want.vpage)
          report_mismatch("victim_page", 32'(rsp.victim_page), 32'(want.vpage));
        if (rsp.victim_owner !== want.vowner)
          report_mismatch("victim_owner", 32'(rsp.victim_owner), 32'(want.vowner));
        if (rsp.victim_dirty !== want.vdirty)
          report_mismatch("victim_dirty", 32'(rsp.victim_dirty), 32'(want.vdirty));
      end
    end
  end

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(ACT_FREE, 6'd0, 8'd0, 20'd0, 1'b0);      // invalid target
    send_request(ACT_ALLOC, 6'd0, 8'd0, 20'd0, 1'b0);     // page zero
    send_request(ACT_ALLOC, 6'd0, 8'hFF, 20'hFFFFF, 1'b1);
    send_request(ACT_TOUCH, 6'd1, 8'd0, 20'd0, 1'b1);
    send_request(ACT_PIN, 6'd0, 8'd0, 20'd0, 1'b0);
    send_request(ACT_UNPIN, 6'd0, 8'd0, 20'd0, 1'b0);
    send_request(ACT_TOUCH, 6'd63, 8'd0, 20'd0, 1'b0);
    send_request(ACT_FREE, 6'd0, 8'd0, 20'd0, 1'b0);
    send_request(ACT_ALLOC, 6'd0, 8'h5A, 20'h12345, 1'b0);
    send_request(ACT_DROP, 6'd0, 8'hFF, 20'd0, 1'b0);
    send_request(3'd6, 6'd0, 8'd0, 20'd0, 1'b0);
    send_request(3'd7, 6'h3F, 8'hFF, 20'hFFFFF, 1'b1);
    send_request(ACT_DROP, 6'd0, 8'h5A, 20'd0, 1'b0);
    send_request(ACT_DROP, 6'd0, 8'd0, 20'd0, 1'b0);
  endtask

  // Fill the table, pin everything for a no-frame walk, then unpin for an eviction.
  task automatic test_all_pinned();
    for (int s = 0; s < FRAMES; s++)
      send_request(ACT_ALLOC, 6'd0, 8'($urandom), 20'($urandom), 1'b0);
    for (int s = 0; s < FRAMES; s++) send_request(ACT_PIN, 6'(s), 8'd0, 20'd0, 1'b0);
    send_request(ACT_ALLOC, 6'd0, 8'h11, 20'h22, 1'b0);
    for (int s = 0; s < FRAMES; s++) send_request(ACT_UNPIN, 6'(s), 8'd0, 20'd0, 1'b0);
    send_request(ACT_TOUCH, 6'd0, 8'd0, 20'd0, 1'b1);
    send_request(ACT_ALLOC, 6'd0, 8'h33, 20'h44, 1'b0);
    wait_drained();
  endtask

  // Mostly a full table with touches and pins so the clock walk stays busy.
  task automatic test_random(input int count);
    logic [2:0] act;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      act = ACT_ALLOC;
      else if (pick < 48) act = ACT_FREE;
      else if (pick < 58) act = ACT_PIN;
      else if (pick < 70) act = ACT_UNPIN;
      else if (pick < 95) act = ACT_TOUCH;
      else if (pick < 98) act = ACT_DROP;
      else                act = 3'($urandom_range(6, 7));
      send_request(act, 6'($urandom), 8'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3)),
                   20'($urandom), 1'($urandom));
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = '0;
    req.frame_slot = '0;
    req.owner = '0;
    req.user_page = '0;
    req.is_write = 1'b0;
    for (int s = 0; s < FRAMES; s++) frame_tbl[s] = '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 20'd0};
    shadow_hand = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_all_pinned();
    test_random(1000);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(150);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Covered %0d responses: %0d evictions, %0d no-frame walks.",
             result_count, evict_count, noframe_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/cfr_pkg.sv
hdl/cfr_ifs.sv
hdl/cfr_frame_mem.sv
hdl/clock_frame_replacement_unit.sv
verif/tb_top.sv
